>>> rtl/core/srrw_pkg.sv
package srrw_pkg;

    // Sizes of the receive window and of the delivery queue.
    localparam int WINDOW_SLOTS = 8;
    localparam int QUEUE_DEPTH  = 8;

    localparam int SEQ_W  = 3;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 4;
    localparam int SLOT_W = $clog2(WINDOW_SLOTS);
    localparam int QA_W   = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    // Distance from the window front to the window rear.
    localparam int WINDOW_SPAN = WINDOW_SLOTS / 2 - 1;
    // At most three slots move into the queue for one frame.
    localparam int MAX_MOVES   = (WINDOW_SPAN < 3) ? WINDOW_SPAN : 3;

    localparam logic [BYTE_W-1:0] END_MARKER_RESET = 8'd26;

    typedef enum logic [2:0] {
        RK_ACK       = 3'd0,
        RK_NAK       = 3'd1,
        RK_DROPPED   = 3'd2,
        RK_DELIVERED = 3'd3,
        RK_DRAINED   = 3'd4,
        RK_EMPTY     = 3'd5,
        RK_IGNORED   = 3'd6
    } result_kind_t;

    typedef struct packed {
        logic                 strobe;
        result_kind_t         kind;
        logic [SEQ_W-1:0]     seq;
        logic [BYTE_W-1:0]    byte_v;
        logic [BYTE_W-1:0]    echo;
        logic [CNT_W-1:0]     count;
        logic                 last;
    } result_t;

    typedef struct packed {
        logic                 wr_en;
        logic [SLOT_W-1:0]    wr_addr;
        logic [BYTE_W-1:0]    wr_data;
        logic                 rd_en;
        logic [SLOT_W-1:0]    rd_addr;
    } slot_req_t;

    typedef struct packed {
        logic                 wr_en;
        logic [QA_W-1:0]      wr_addr;
        logic [BYTE_W-1:0]    wr_data;
        logic                 rd_en;
        logic [QA_W-1:0]      rd_addr;
    } queue_req_t;

    // The sequence number is below twice the slot count, so one
    // compare and subtract gives the slot.
    function automatic logic [SLOT_W-1:0] slot_of_seq(input logic [SEQ_W-1:0] seq);
        logic [7:0] s;
        s = {5'b00000, seq};
        if (s >= 8'(WINDOW_SLOTS))
        begin
            s = s - 8'(WINDOW_SLOTS);
        end
        return s[SLOT_W-1:0];
    endfunction

    // The reported occupancy keeps the low four bits of the fill count.
    function automatic logic [CNT_W-1:0] count_out(input logic [FILL_W-1:0] f);
        logic [FILL_W+CNT_W-1:0] w;
        w = {{CNT_W{1'b0}}, f};
        return w[CNT_W-1:0];
    endfunction

endpackage

>>> rtl/core/srrw_ram.sv
module srrw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/srrw_ctrl.sv
module srrw_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            kind,
    input  logic [srrw_pkg::SEQ_W-1:0]      seq_num,
    input  logic [srrw_pkg::BYTE_W-1:0]     data_byte,
    input  logic [srrw_pkg::BYTE_W-1:0]     check_value,
    input  logic                            frame_ok,
    input  logic [srrw_pkg::BYTE_W-1:0]     end_marker,
    input  logic [srrw_pkg::BYTE_W-1:0]     slot_rd_data,
    input  logic [srrw_pkg::BYTE_W-1:0]     queue_rd_data,
    output srrw_pkg::slot_req_t             slot_req,
    output srrw_pkg::queue_req_t            queue_req,
    output srrw_pkg::result_t               result
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RESP,
        ST_DLV,
        ST_DRAIN
    } state_t;

    state_t                           state_reg, state_next;
    logic [srrw_pkg::SLOT_W-1:0]      front_reg, front_next;
    logic [srrw_pkg::SLOT_W-1:0]      rear_reg, rear_next;
    logic [srrw_pkg::QA_W-1:0]        head_reg, head_next;
    logic [srrw_pkg::QA_W-1:0]        tail_reg, tail_next;
    logic [srrw_pkg::FILL_W-1:0]      fill_reg, fill_next;
    logic                             done_reg, done_next;
    logic [srrw_pkg::WINDOW_SLOTS-1:0] received_reg, received_next;
    logic [1:0]                       moved_reg, moved_next;
    logic [srrw_pkg::SEQ_W-1:0]       seq_reg, seq_next;
    logic [srrw_pkg::BYTE_W-1:0]      check_reg, check_next;
    logic                             ok_reg, ok_next;
    logic                             is_end_reg, is_end_next;
    srrw_pkg::result_t                result_reg, result_next;

    logic [srrw_pkg::WINDOW_SLOTS-1:0] rcv_cleared;
    logic [srrw_pkg::SLOT_W-1:0]      front_inc;
    logic [srrw_pkg::SLOT_W-1:0]      new_slot;
    logic                             more;

    function automatic logic [srrw_pkg::SLOT_W-1:0] slot_inc(
        input logic [srrw_pkg::SLOT_W-1:0] x);
        return (x == srrw_pkg::SLOT_W'(srrw_pkg::WINDOW_SLOTS - 1)) ? '0 : x + 1'b1;
    endfunction

    function automatic logic [srrw_pkg::QA_W-1:0] queue_inc(
        input logic [srrw_pkg::QA_W-1:0] x);
        return (x == srrw_pkg::QA_W'(srrw_pkg::QUEUE_DEPTH - 1)) ? '0 : x + 1'b1;
    endfunction

    function automatic logic [srrw_pkg::SLOT_W-1:0] slot_plus_span(
        input logic [srrw_pkg::SLOT_W-1:0] f);
        logic [srrw_pkg::SLOT_W:0] t;
        t = {1'b0, f} + (srrw_pkg::SLOT_W + 1)'(srrw_pkg::WINDOW_SPAN);
        if (t >= (srrw_pkg::SLOT_W + 1)'(srrw_pkg::WINDOW_SLOTS))
        begin
            t = t - (srrw_pkg::SLOT_W + 1)'(srrw_pkg::WINDOW_SLOTS);
        end
        return t[srrw_pkg::SLOT_W-1:0];
    endfunction

    // One delivery step: the slot at the rear is released and the front
    // moves on by one.
    always_comb
    begin
        rcv_cleared = received_reg;
        rcv_cleared[rear_reg] = 1'b0;
        front_inc = slot_inc(front_reg);
        new_slot = srrw_pkg::slot_of_seq(seq_num);
        more = (({1'b0, moved_reg} + 3'd1) < 3'(srrw_pkg::MAX_MOVES))
            && (({1'b0, fill_reg} + 1'b1) < (srrw_pkg::FILL_W + 1)'(srrw_pkg::QUEUE_DEPTH))
            && rcv_cleared[front_inc];
    end

    always_comb
    begin
        state_next    = state_reg;
        front_next    = front_reg;
        rear_next     = rear_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        fill_next     = fill_reg;
        done_next     = done_reg;
        received_next = received_reg;
        moved_next    = moved_reg;
        seq_next      = seq_reg;
        check_next    = check_reg;
        ok_next       = ok_reg;
        is_end_next   = is_end_reg;
        result_next   = '0;
        slot_req      = '0;
        queue_req     = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    seq_next    = seq_num;
                    check_next  = check_value;
                    ok_next     = frame_ok;
                    is_end_next = frame_ok && (data_byte == end_marker);
                    result_next.count = srrw_pkg::count_out(fill_reg);
                    if (kind)
                    begin
                        if (fill_reg == '0)
                        begin
                            result_next.strobe = 1'b1;
                            result_next.kind   = srrw_pkg::RK_EMPTY;
                            result_next.last   = 1'b1;
                        end
                        else
                        begin
                            queue_req.rd_en   = 1'b1;
                            queue_req.rd_addr = head_reg;
                            state_next        = ST_DRAIN;
                        end
                    end
                    else if (done_reg)
                    begin
                        result_next.strobe = 1'b1;
                        result_next.kind   = srrw_pkg::RK_IGNORED;
                        result_next.last   = 1'b1;
                    end
                    else if (fill_reg >= srrw_pkg::FILL_W'(srrw_pkg::QUEUE_DEPTH))
                    begin
                        result_next.strobe = 1'b1;
                        result_next.kind   = srrw_pkg::RK_DROPPED;
                        result_next.last   = 1'b1;
                    end
                    else
                    begin
                        if (frame_ok)
                        begin
                            slot_req.wr_en   = 1'b1;
                            slot_req.wr_addr = new_slot;
                            slot_req.wr_data = data_byte;
                            if (data_byte == end_marker)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                received_next[new_slot] = 1'b1;
                            end
                        end
                        state_next = ST_RESP;
                    end
                end
            end

            ST_RESP:
            begin
                result_next.strobe = 1'b1;
                result_next.kind   = ok_reg ? srrw_pkg::RK_ACK : srrw_pkg::RK_NAK;
                result_next.seq    = seq_reg;
                result_next.echo   = check_reg;
                result_next.count  = srrw_pkg::count_out(fill_reg);
                if (!is_end_reg && received_reg[front_reg])
                begin
                    slot_req.rd_en   = 1'b1;
                    slot_req.rd_addr = front_reg;
                    moved_next       = '0;
                    state_next       = ST_DLV;
                end
                else
                begin
                    result_next.last = 1'b1;
                    state_next       = ST_IDLE;
                end
            end

            ST_DLV:
            begin
                queue_req.wr_en   = 1'b1;
                queue_req.wr_addr = tail_reg;
                queue_req.wr_data = slot_rd_data;
                tail_next         = queue_inc(tail_reg);
                fill_next         = fill_reg + 1'b1;
                front_next        = front_inc;
                rear_next         = slot_inc(rear_reg);
                received_next     = rcv_cleared;
                moved_next        = moved_reg + 1'b1;
                result_next.strobe = 1'b1;
                result_next.kind   = srrw_pkg::RK_DELIVERED;
                result_next.byte_v = slot_rd_data;
                result_next.count  = srrw_pkg::count_out(fill_reg + 1'b1);
                result_next.last   = !more;
                if (more)
                begin
                    slot_req.rd_en   = 1'b1;
                    slot_req.rd_addr = front_inc;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_DRAIN:
            begin
                head_next          = queue_inc(head_reg);
                fill_next          = fill_reg - 1'b1;
                result_next.strobe = 1'b1;
                result_next.kind   = srrw_pkg::RK_DRAINED;
                result_next.byte_v = queue_rd_data;
                result_next.count  = srrw_pkg::count_out(fill_reg - 1'b1);
                result_next.last   = 1'b1;
                state_next         = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            front_reg    <= '0;
            rear_reg     <= srrw_pkg::SLOT_W'(srrw_pkg::WINDOW_SPAN);
            head_reg     <= '0;
            tail_reg     <= '0;
            fill_reg     <= '0;
            done_reg     <= 1'b0;
            received_reg <= '0;
            moved_reg    <= '0;
            result_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            front_reg    <= front_next;
            rear_reg     <= rear_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            fill_reg     <= fill_next;
            done_reg     <= done_next;
            received_reg <= received_next;
            moved_reg    <= moved_next;
            result_reg   <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seq_reg    <= seq_next;
        check_reg  <= check_next;
        ok_reg     <= ok_next;
        is_end_reg <= is_end_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign result = result_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= srrw_pkg::FILL_W'(srrw_pkg::QUEUE_DEPTH))
        else $error("delivery queue fill beyond its depth");

    a_rear_tracks_front: assert property (@(posedge clk) disable iff (!rst_n)
        rear_reg == slot_plus_span(front_reg))
        else $error("window rear lost its distance to the front");

    a_drain_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DRAIN |=> result_reg.strobe && result_reg.last)
        else $error("drain did not finish with a single final result");

    a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
        result_reg.strobe && !result_reg.last |-> state_reg == ST_DLV)
        else $error("a non-final result without a delivery step behind it");

endmodule

>>> rtl/core/selective_repeat_receive_window.sv
// Receive side of a selective-repeat sliding-window link with an in-order
// delivery queue.
//
// Input transactions are taken at a rising edge with start high and busy low.
// kind selects a frame (0) or a drain of one queued byte (1). Each result is
// on the result ports for exactly one cycle while result_valid is high; last
// marks the final result of a transaction. The receiver cannot stall, so the
// block never waits on the result side.
//
// A drain, a frame after the end marker or a frame dropped on a full queue
// gives one result, registered as it is accepted; a drain that reads the
// queue memory gives it from the drain state. A frame gives its ack or nak
// from the response state, then one delivered byte per cycle for up to
// three window slots. busy stays low when the result comes straight away;
// it is high in the drain state for a drain that reads the queue, and in
// the response and delivery states for a frame. The delivery sequencer
// sets the slot count, moving one slot a cycle through the slot memory.
// A new transaction may be accepted while the final result is on the ports.
//
// The end_marker register is written over the cfg channel while busy is low.
// Reset clears the window, the queue pointers and the end flag at once and
// restores end_marker to 26; the slot and queue memories are not cleared.
module selective_repeat_receive_window (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            kind,
    input  logic [srrw_pkg::SEQ_W-1:0]      seq_num,
    input  logic [srrw_pkg::BYTE_W-1:0]     data_byte,
    input  logic [srrw_pkg::BYTE_W-1:0]     check_value,
    input  logic                            frame_ok,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [srrw_pkg::BYTE_W-1:0]     cfg_data,
    output logic                            result_valid,
    output logic [2:0]                      result_kind,
    output logic [srrw_pkg::SEQ_W-1:0]      seq_value,
    output logic [srrw_pkg::BYTE_W-1:0]     byte_value,
    output logic [srrw_pkg::BYTE_W-1:0]     echo_check,
    output logic [srrw_pkg::CNT_W-1:0]      queue_count,
    output logic                            last
);

    logic [srrw_pkg::BYTE_W-1:0] end_marker_reg, end_marker_next;
    logic [srrw_pkg::BYTE_W-1:0] slot_rd_data;
    logic [srrw_pkg::BYTE_W-1:0] queue_rd_data;
    srrw_pkg::slot_req_t         slot_req;
    srrw_pkg::queue_req_t        queue_req;
    srrw_pkg::result_t           result;

    // The register only changes between transactions.
    assign cfg_ready = !busy;

    always_comb
    begin
        end_marker_next = end_marker_reg;
        if (cfg_valid && cfg_ready)
        begin
            end_marker_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_marker_reg <= srrw_pkg::END_MARKER_RESET;
        end
        else
        begin
            end_marker_reg <= end_marker_next;
        end
    end

    // Window slot bytes: written by good frames, read by delivery.
    srrw_ram #(
        .WIDTH (srrw_pkg::BYTE_W),
        .DEPTH (srrw_pkg::WINDOW_SLOTS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (slot_req.wr_en),
        .wr_addr (slot_req.wr_addr),
        .wr_data (slot_req.wr_data),
        .rd_en   (slot_req.rd_en),
        .rd_addr (slot_req.rd_addr),
        .rd_data (slot_rd_data)
    );

    // Delivery queue bytes: written by delivery, read by drains.
    srrw_ram #(
        .WIDTH (srrw_pkg::BYTE_W),
        .DEPTH (srrw_pkg::QUEUE_DEPTH)
    ) u_queue_ram (
        .clk     (clk),
        .wr_en   (queue_req.wr_en),
        .wr_addr (queue_req.wr_addr),
        .wr_data (queue_req.wr_data),
        .rd_en   (queue_req.rd_en),
        .rd_addr (queue_req.rd_addr),
        .rd_data (queue_rd_data)
    );

    srrw_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .seq_num       (seq_num),
        .data_byte     (data_byte),
        .check_value   (check_value),
        .frame_ok      (frame_ok),
        .end_marker    (end_marker_reg),
        .slot_rd_data  (slot_rd_data),
        .queue_rd_data (queue_rd_data),
        .slot_req      (slot_req),
        .queue_req     (queue_req),
        .result        (result)
    );

    assign result_valid = result.strobe;
    assign result_kind  = result.kind;
    assign seq_value    = result.seq;
    assign byte_value   = result.byte_v;
    assign echo_check   = result.echo;
    assign queue_count  = result.count;
    assign last         = result.last;

endmodule
